// ===== rtl/pidc_pkg.sv =====
// Shared types and constants for the clamped PID controller.
// Used by every module under rtl; depends on nothing.
package pidc_pkg;

  // Field widths
  localparam int unsigned DATA_W = 16;
  localparam int unsigned ERR_W  = 17;
  localparam int unsigned DIFF_W = 18;
  localparam int unsigned SUM_W  = 24;
  localparam int unsigned OFS_W  = 15;
  localparam int unsigned CFG_W  = 24;
  localparam int unsigned IDX_W  = 3;

  // Product and accumulation widths
  localparam int unsigned PP_W  = DATA_W + ERR_W;
  localparam int unsigned PI_W  = DATA_W + SUM_W;
  localparam int unsigned PD_W  = DATA_W + DIFF_W;
  localparam int unsigned RAW_W = PI_W + 2;
  localparam int unsigned Y_W   = RAW_W + 1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUT_OFFSET = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUT_UPPER  = 3'd4;
  localparam logic [IDX_W-1:0] REG_OUT_LOWER  = 3'd5;
  localparam logic [IDX_W-1:0] REG_SUM_UPPER  = 3'd6;
  localparam logic [IDX_W-1:0] REG_SUM_LOWER  = 3'd7;

  // Configuration bundle
  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] deriv_gain;
    logic        [OFS_W-1:0]  output_offset;
    logic signed [DATA_W-1:0] output_upper;
    logic signed [DATA_W-1:0] output_lower;
    logic signed [SUM_W-1:0]  sum_upper;
    logic signed [SUM_W-1:0]  sum_lower;
  } pidc_cfg_t;

  // Input item
  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
    logic                     clear;
  } pidc_in_t;

  // Error stage result
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIFF_W-1:0] diff;
    logic                     clr;
  } pidc_err_t;

  // Product stage result
  typedef struct packed {
    logic signed [PP_W-1:0] p;
    logic signed [PI_W-1:0] i;
    logic signed [PD_W-1:0] d;
    logic                   clr;
  } pidc_prod_t;

endpackage

// ===== rtl/pidc_err.sv =====
// Input register and error stage: error, clamped integral, error difference.
// Holds the controller state. Depends on pidc_pkg.
module pidc_err
  import pidc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  pidc_cfg_t  cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  pidc_in_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output pidc_err_t  out_item
);

  logic                     in_v_r;
  pidc_in_t                 in_r;
  logic                     st_v_r;
  pidc_err_t                st_r;
  logic signed [ERR_W-1:0]  prev_err_r;
  logic signed [SUM_W-1:0]  err_sum_r;

  logic                     st_ready;
  logic                     adv;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W:0]    sum_acc;
  logic signed [SUM_W:0]    sum_clamped;
  logic signed [SUM_W-1:0]  sum_nxt;
  pidc_err_t                st_nxt;

  // Stage handshake
  assign st_ready = !st_v_r || out_ready;
  assign adv      = in_v_r && st_ready;
  assign in_ready = !in_v_r || st_ready;

  // Error and integral update
  always_comb begin
    err         = ERR_W'(in_r.setpoint) - ERR_W'(in_r.measured);
    sum_acc     = (SUM_W+1)'(err_sum_r) + (SUM_W+1)'(err);
    sum_clamped = sum_acc;
    if (sum_clamped > (SUM_W+1)'(cfg.sum_upper)) sum_clamped = (SUM_W+1)'(cfg.sum_upper);
    if (sum_clamped < (SUM_W+1)'(cfg.sum_lower)) sum_clamped = (SUM_W+1)'(cfg.sum_lower);
    if (cfg.integ_gain != '0) begin
      sum_nxt = sum_clamped[SUM_W-1:0];
    end else begin
      sum_nxt = '0;
    end
    if (in_r.clear) begin
      st_nxt.err  = '0;
      st_nxt.sum  = '0;
      st_nxt.diff = '0;
      st_nxt.clr  = 1'b1;
    end else begin
      st_nxt.err  = err;
      st_nxt.sum  = sum_nxt;
      st_nxt.diff = DIFF_W'(err) - DIFF_W'(prev_err_r);
      st_nxt.clr  = 1'b0;
    end
  end

  // Advance valid flags and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      st_v_r     <= 1'b0;
      prev_err_r <= '0;
      err_sum_r  <= '0;
    end else begin
      in_v_r <= (in_valid && in_ready) || (in_v_r && !st_ready);
      st_v_r <= adv || (st_v_r && !out_ready);
      if (adv) begin
        prev_err_r <= st_nxt.err;
        err_sum_r  <= st_nxt.sum;
      end
    end
  end

  // Hold payloads
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_item;
    if (adv) st_r <= st_nxt;
  end

  assign out_valid = st_v_r;
  assign out_item  = st_r;

endmodule

// ===== rtl/pidc_mul.sv =====
// Product stage: the three gain multiplies, registered.
// Depends on pidc_pkg.
module pidc_mul
  import pidc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pidc_cfg_t   cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  pidc_err_t   in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output pidc_prod_t  out_item
);

  logic        v_r;
  pidc_prod_t  prod_r;
  pidc_prod_t  prod_nxt;
  logic        adv;

  assign in_ready = !v_r || out_ready;
  assign adv      = in_valid && in_ready;

  // Multiply each term by its gain
  always_comb begin
    prod_nxt.p   = PP_W'(cfg.prop_gain)  * PP_W'(in_item.err);
    prod_nxt.i   = PI_W'(cfg.integ_gain) * PI_W'(in_item.sum);
    prod_nxt.d   = PD_W'(cfg.deriv_gain) * PD_W'(in_item.diff);
    prod_nxt.clr = in_item.clr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= adv || (v_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) prod_r <= prod_nxt;
  end

  assign out_valid = v_r;
  assign out_item  = prod_r;

endmodule

// ===== rtl/pidc_out.sv =====
// Output stage: sum products, floor-scale, apply offset and saturate.
// Depends on pidc_pkg.
module pidc_out
  import pidc_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pidc_cfg_t                 cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pidc_prod_t                in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DATA_W-1:0]  out_drive
);

  logic                      v_r;
  logic signed [DATA_W-1:0]  drive_r;
  logic signed [DATA_W-1:0]  drive_nxt;
  logic signed [RAW_W-1:0]   raw;
  logic signed [RAW_W-1:0]   scaled;
  logic signed [Y_W-1:0]     y;
  logic                      adv;

  assign in_ready = !v_r || out_ready;
  assign adv      = in_valid && in_ready;

  // Combine terms, push away from zero, clip to the limits; a clear drives zero
  always_comb begin
    raw    = RAW_W'(in_item.p) + RAW_W'(in_item.i) + RAW_W'(in_item.d);
    scaled = raw >>> FRAC_BITS;
    y      = Y_W'(scaled);
    if (raw > 0) y = y + Y_W'({1'b0, cfg.output_offset});
    if (raw < 0) y = y - Y_W'({1'b0, cfg.output_offset});
    if (y > Y_W'(cfg.output_upper)) y = Y_W'(cfg.output_upper);
    if (y < Y_W'(cfg.output_lower)) y = Y_W'(cfg.output_lower);
    if (in_item.clr) begin
      drive_nxt = '0;
    end else begin
      drive_nxt = y[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= adv || (v_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) drive_r <= drive_nxt;
  end

  assign out_valid = v_r;
  assign out_drive = drive_r;

endmodule

// ===== rtl/pid_controller_clamped.sv =====
// Top level of the clamped positional PID controller: configuration
// registers and the error, product and output stages. Depends on pidc_pkg.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready  in_setpoint, in_measured, in_clear
//   out_     output     out_valid/out_ready  out_drive
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ready is high; an item passes the
// input register, then the error, multiply and output registers, to out_valid.
// The error stage updates the kept error and integral as an item advances.
// Reset is synchronous, clears valid flags and state, and sets default config.
// Each stage holds its item while the next one is full and stalled, so
// in_ready stays high as long as any stage has room.
module pid_controller_clamped
  import pidc_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [DATA_W-1:0]  in_setpoint,
  input  logic signed [DATA_W-1:0]  in_measured,
  input  logic                      in_clear,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DATA_W-1:0]  out_drive,
  input  logic                      cfg_we,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  pidc_cfg_t   cfg_r;
  pidc_in_t    in_item;
  pidc_err_t   err_item;
  pidc_prod_t  prod_item;
  logic        err_valid;
  logic        err_ready;
  logic        prod_valid;
  logic        prod_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= '0;
      cfg_r.integ_gain    <= '0;
      cfg_r.deriv_gain    <= '0;
      cfg_r.output_offset <= '0;
      cfg_r.output_upper  <= 16'sh7FFF;
      cfg_r.output_lower  <= 16'sh8000;
      cfg_r.sum_upper     <= 24'sh7FFFFF;
      cfg_r.sum_lower     <= 24'sh800000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  cfg_r.prop_gain     <= cfg_wdata[DATA_W-1:0];
        REG_INTEG_GAIN: cfg_r.integ_gain    <= cfg_wdata[DATA_W-1:0];
        REG_DERIV_GAIN: cfg_r.deriv_gain    <= cfg_wdata[DATA_W-1:0];
        REG_OUT_OFFSET: cfg_r.output_offset <= cfg_wdata[OFS_W-1:0];
        REG_OUT_UPPER:  cfg_r.output_upper  <= cfg_wdata[DATA_W-1:0];
        REG_OUT_LOWER:  cfg_r.output_lower  <= cfg_wdata[DATA_W-1:0];
        REG_SUM_UPPER:  cfg_r.sum_upper     <= cfg_wdata[SUM_W-1:0];
        REG_SUM_LOWER:  cfg_r.sum_lower     <= cfg_wdata[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  // Pack the input item
  assign in_item.setpoint = in_setpoint;
  assign in_item.measured = in_measured;
  assign in_item.clear    = in_clear;

  pidc_err u_err (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (err_valid),
    .out_ready (err_ready),
    .out_item  (err_item)
  );

  pidc_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_item   (err_item),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_item  (prod_item)
  );

  pidc_out #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_item   (prod_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_drive (out_drive)
  );

endmodule
